// File: sv/drd_pkg.sv
// drd_pkg: widths, register indexes, row record type and helpers for the
// detection row decoder; used by the interfaces and every module of the block
package drd_pkg;

   localparam int VALUE_W     = 24;
   localparam int FRAC_BITS   = 12;
   localparam int BOX_FIELDS  = 5;
   localparam int COORD_W     = 12;
   localparam int EDGE_W      = COORD_W + 1;
   localparam int CLASS_W     = 8;
   localparam int POS_W       = 9;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = VALUE_W;
   localparam int PROD_W      = 2 * VALUE_W;

   localparam logic [CSR_INDEX_W-1:0] REG_SCORE_THRESHOLD = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_CLASS_COUNT     = CSR_INDEX_W'(1);

   localparam logic [VALUE_W-1:0] THRESHOLD_RESET   = VALUE_W'(2048);
   localparam logic [CLASS_W-1:0] CLASS_COUNT_RESET = CLASS_W'(80);

   localparam logic [POS_W-1:0] POS_OBJECTNESS = POS_W'(BOX_FIELDS - 1);
   localparam logic [POS_W-1:0] POS_FIRST_CLASS = POS_W'(BOX_FIELDS);
   localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};

   // one finished row that passed the threshold
   typedef struct packed {
      logic [COORD_W-1:0] center_x;
      logic [COORD_W-1:0] center_y;
      logic [COORD_W-1:0] size_w;
      logic [COORD_W-1:0] size_h;
      logic [VALUE_W-1:0] objectness;
      logic [VALUE_W-1:0] best_score;
      logic [CLASS_W-1:0] best_class;
   } row_box_type;

   typedef struct packed {
      logic        box_valid;
      row_box_type box;
   } row_done_type;

   // integer part of a fixed point value, saturated to the coordinate range
   function automatic logic [COORD_W-1:0] int_part(input logic [VALUE_W-1:0] v);
      logic [VALUE_W-1:0] shifted;
      shifted = v >> FRAC_BITS;
      if (shifted > VALUE_W'(COORD_MAX)) begin
         return COORD_MAX;
      end
      return shifted[COORD_W-1:0];
   endfunction

endpackage

// File: sv/drd_req_if.sv
// drd_req_if: request channel of the detection row decoder, one tensor value
// per request; depends on drd_pkg
interface drd_req_if;
   logic                        valid;
   logic                        ready;
   logic [drd_pkg::VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

// File: sv/drd_rsp_if.sv
// drd_rsp_if: result channel of the detection row decoder, one decoded box
// per passing row; depends on drd_pkg
interface drd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [drd_pkg::EDGE_W-1:0]  box_left;
   logic signed [drd_pkg::EDGE_W-1:0]  box_top;
   logic        [drd_pkg::COORD_W-1:0] box_width;
   logic        [drd_pkg::COORD_W-1:0] box_height;
   logic        [drd_pkg::VALUE_W-1:0] confidence;
   logic        [drd_pkg::CLASS_W-1:0] class_index;

   modport source (output valid, output box_left, output box_top, output box_width,
                   output box_height, output confidence, output class_index,
                   input ready);
   modport sink   (input valid, input box_left, input box_top, input box_width,
                   input box_height, input confidence, input class_index,
                   output ready);
endinterface

// File: sv/detection_row_decode.sv
// detection_row_decode: top level of the detector output row decoder; uses
// drd_pkg, drd_req_if, drd_rsp_if and drd_row_track
//
// The block takes a detector output tensor one value per request, row-major:
// each row is center x, center y, width, height, objectness and then
// class_count class scores, all unsigned Q12.12. It accepts one value every
// clock cycle while the result side keeps up. At the last value of a row it
// produces one box when objectness is strictly above score_threshold; the box
// passes the row record and then the output register, which is loaded with the
// result of the 24x24 confidence multiply and the edge subtraction. A two-entry
// path (row record and output register) lets rows keep streaming while a box
// waits on rsp.ready. Register writes belong in idle time and do not restart
// a row in progress.
module detection_row_decode (
   input  logic                             clock,
   input  logic                             reset,
   drd_req_if.sink                          req,
   drd_rsp_if.source                        rsp,
   input  logic                             csr_write_en,
   input  logic [drd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [drd_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import drd_pkg::*;

   logic [VALUE_W-1:0] threshold_ff;
   logic [CLASS_W-1:0] class_count_ff;

   row_done_type done;
   row_box_type  rec_ff;
   logic         rec_valid_ff, rec_valid_in;
   logic         out_valid_ff;
   logic         out_load;
   logic         rec_move;
   logic         accept;

   logic [PROD_W-1:0]  product;
   logic [PROD_W-1:0]  conf_wide;
   logic [VALUE_W-1:0] conf_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= THRESHOLD_RESET;
         class_count_ff <= CLASS_COUNT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_SCORE_THRESHOLD: threshold_ff   <= csr_write_data[VALUE_W-1:0];
            REG_CLASS_COUNT:     class_count_ff <= csr_write_data[CLASS_W-1:0];
            default: ;
         endcase
      end
   end

   assign out_load  = !out_valid_ff || rsp.ready;
   assign rec_move  = rec_valid_ff && out_load;
   assign req.ready = !rec_valid_ff || out_load;
   assign accept    = req.valid && req.ready;

   drd_row_track u_row_track (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .value           (req.value),
      .score_threshold (threshold_ff),
      .class_count     (class_count_ff),
      .done            (done)
   );

   always_comb begin
      rec_valid_in = rec_valid_ff;
      if (done.box_valid) begin
         rec_valid_in = 1'b1;
      end else if (rec_move) begin
         rec_valid_in = 1'b0;
      end
   end

   // confidence is the Q12.12 product, saturated to the value width
   assign product   = PROD_W'(rec_ff.objectness) * PROD_W'(rec_ff.best_score);
   assign conf_wide = product >> FRAC_BITS;
   assign conf_sat  = (conf_wide > PROD_W'({VALUE_W{1'b1}})) ? {VALUE_W{1'b1}}
                                                            : conf_wide[VALUE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rec_valid_ff <= rec_valid_in;
         if (out_load) begin
            out_valid_ff <= rec_valid_ff;
         end
      end
      if (done.box_valid) begin
         rec_ff <= done.box;
      end
      if (rec_move) begin
         rsp.box_left    <= $signed({1'b0, rec_ff.center_x})
                          - $signed({2'b00, rec_ff.size_w[COORD_W-1:1]});
         rsp.box_top     <= $signed({1'b0, rec_ff.center_y})
                          - $signed({2'b00, rec_ff.size_h[COORD_W-1:1]});
         rsp.box_width   <= rec_ff.size_w;
         rsp.box_height  <= rec_ff.size_h;
         rsp.confidence  <= conf_sat;
         rsp.class_index <= rec_ff.best_class;
      end
   end

   assign rsp.valid = out_valid_ff;

endmodule

// File: sv/drd_row_track.sv
// drd_row_track: walks one tensor row per pass, keeps box fields and the
// running best class score, flags a passing box at row end; uses drd_pkg
module drd_row_track (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [drd_pkg::VALUE_W-1:0] value,
   input  logic [drd_pkg::VALUE_W-1:0] score_threshold,
   input  logic [drd_pkg::CLASS_W-1:0] class_count,
   output drd_pkg::row_done_type       done
);
   import drd_pkg::*;

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [COORD_W-1:0] cx_ff, cx_in, cy_ff, cy_in, w_ff, w_in, h_ff, h_in;
   logic [VALUE_W-1:0] obj_ff, obj_in, best_ff, best_in;
   logic [CLASS_W-1:0] cls_ff, cls_in;
   logic [POS_W-1:0]   row_last;
   logic [POS_W-1:0]   class_pos;
   logic               row_end;

   assign row_last  = POS_OBJECTNESS + POS_W'(class_count);
   assign class_pos = pos_ff - POS_FIRST_CLASS;
   assign row_end   = pos_ff >= row_last;

   always_comb begin
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      w_in    = w_ff;
      h_in    = h_ff;
      obj_in  = obj_ff;
      best_in = best_ff;
      cls_in  = cls_ff;
      case (pos_ff)
         POS_W'(0): cx_in  = int_part(value);
         POS_W'(1): cy_in  = int_part(value);
         POS_W'(2): w_in   = int_part(value);
         POS_W'(3): h_in   = int_part(value);
         POS_OBJECTNESS: obj_in = value;
         default: begin
            // later class wins only when strictly greater
            if (value > best_ff) begin
               best_in = value;
               cls_in  = class_pos[CLASS_W-1:0];
            end
         end
      endcase
   end

   always_comb begin
      done.box_valid      = accept && row_end && (obj_in > score_threshold);
      done.box.center_x   = cx_in;
      done.box.center_y   = cy_in;
      done.box.size_w     = w_in;
      done.box.size_h     = h_in;
      done.box.objectness = obj_in;
      done.box.best_score = best_in;
      done.box.best_class = cls_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && row_end)) begin
         pos_ff  <= '0;
         cx_ff   <= '0;
         cy_ff   <= '0;
         w_ff    <= '0;
         h_ff    <= '0;
         obj_ff  <= '0;
         best_ff <= '0;
         cls_ff  <= '0;
      end else if (accept) begin
         pos_ff  <= pos_ff + POS_W'(1);
         cx_ff   <= cx_in;
         cy_ff   <= cy_in;
         w_ff    <= w_in;
         h_ff    <= h_in;
         obj_ff  <= obj_in;
         best_ff <= best_in;
         cls_ff  <= cls_in;
      end
   end

endmodule

// File: tb/sv/detection_row_decode_tb.sv
// detection_row_decode_tb: self-checking testbench for the detector row decoder,
// streams tensor rows under several register settings and idle patterns
// depends on drd_pkg, drd_req_if, drd_rsp_if and detection_row_decode
module detection_row_decode_tb;
   import drd_pkg::*;

   localparam int IDLE_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_LOW  = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_HIGH = {CSR_INDEX_W{1'b1}};
   localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

   typedef struct {
      logic signed [EDGE_W-1:0] left;
      logic signed [EDGE_W-1:0] top;
      logic [COORD_W-1:0]       width;
      logic [COORD_W-1:0]       height;
      logic [VALUE_W-1:0]       confidence;
      logic [CLASS_W-1:0]       class_index;
   } box_type;

   // row decoder prediction and the queue of boxes still owed by the block
   class box_scoreboard;
      logic [VALUE_W-1:0] threshold;
      logic [CLASS_W-1:0] class_count;
      int unsigned        position;
      logic [COORD_W-1:0] center_x, center_y, size_w, size_h;
      logic [VALUE_W-1:0] objectness, best_score;
      logic [CLASS_W-1:0] best_class;
      box_type            boxes_due[$];
      int                 mismatches;
      int                 boxes_checked;
      int                 rows_done;
      int                 values_seen;

      function void clear_row();
         position = 0;
         center_x = '0;
         center_y = '0;
         size_w = '0;
         size_h = '0;
         objectness = '0;
         best_score = '0;
         best_class = '0;
      endfunction

      function void restart();
         threshold = THRESHOLD_RESET;
         class_count = CLASS_COUNT_RESET;
         mismatches = 0;
         boxes_checked = 0;
         rows_done = 0;
         values_seen = 0;
         boxes_due.delete();
         clear_row();
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_SCORE_THRESHOLD: threshold = data[VALUE_W-1:0];
            REG_CLASS_COUNT:     class_count = data[CLASS_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [COORD_W-1:0] whole_pixels(logic [VALUE_W-1:0] v);
         logic [VALUE_W-1:0] ip;
         ip = v >> FRAC_BITS;
         if (ip > VALUE_W'(COORD_MAX)) begin
            return COORD_MAX;
         end
         return ip[COORD_W-1:0];
      endfunction

      function void note_value(logic [VALUE_W-1:0] v);
         box_type            b;
         logic [PROD_W-1:0]  prod;
         values_seen++;
         case (position)
            0: center_x = whole_pixels(v);
            1: center_y = whole_pixels(v);
            2: size_w = whole_pixels(v);
            3: size_h = whole_pixels(v);
            BOX_FIELDS - 1: objectness = v;
            default: begin
               // strict compare keeps the first of equal scores
               if (position - BOX_FIELDS < 255 && v > best_score) begin
                  best_score = v;
                  best_class = CLASS_W'(position - BOX_FIELDS);
               end
            end
         endcase
         if (position >= BOX_FIELDS - 1 && position >= BOX_FIELDS - 1 + class_count) begin
            rows_done++;
            if (objectness > threshold) begin
               b.left = $signed({1'b0, center_x}) - $signed({1'b0, size_w >> 1});
               b.top = $signed({1'b0, center_y}) - $signed({1'b0, size_h >> 1});
               b.width = size_w;
               b.height = size_h;
               prod = (PROD_W'(objectness) * PROD_W'(best_score)) >> FRAC_BITS;
               b.confidence = (prod > PROD_W'(VALUE_MAX)) ? VALUE_MAX : prod[VALUE_W-1:0];
               b.class_index = best_class;
               boxes_due = {boxes_due, b};
            end
            clear_row();
         end else begin
            position++;
         end
      endfunction

      function void compare_field(string name, longint want, longint got);
         if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_box(box_type got);
         box_type want;
         if (boxes_due.size() == 0) begin
            $display("%0t: box with none expected, actual left %0d top %0d class %0d",
                     $time, got.left, got.top, got.class_index);
            mismatches++;
            return;
         end
         want = boxes_due.pop_front();
         boxes_checked++;
         compare_field("box_left", want.left, got.left);
         compare_field("box_top", want.top, got.top);
         compare_field("box_width", want.width, got.width);
         compare_field("box_height", want.height, got.height);
         compare_field("confidence", want.confidence, got.confidence);
         compare_field("class_index", want.class_index, got.class_index);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   drd_req_if req_ch ();
   drd_rsp_if rsp_ch ();

   detection_row_decode uut (
      .clock          (clock),
      .reset          (reset),
      .req            (req_ch),
      .rsp            (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   box_scoreboard sb;
   box_type       seen;
   int            idle_pct = 0;
   int            stall_pct = 0;
   int            quiet_cycles = 0;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.value = '0;
      rsp_ch.ready = 1'b0;
   end

   always #5 clock = ~clock;

   // watch both channels, then pick the next ready level
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            sb.note_value(req_ch.value);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.left = rsp_ch.box_left;
            seen.top = rsp_ch.box_top;
            seen.width = rsp_ch.box_width;
            seen.height = rsp_ch.box_height;
            seen.confidence = rsp_ch.confidence;
            seen.class_index = rsp_ch.class_index;
            sb.check_box(seen);
         end
      end
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
               $display("FAIL detection_row_decode");
               $finish;
            end
         end
      end
   end

   task automatic send_value(input logic [VALUE_W-1:0] v);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.value <= v;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // hold off requests until every box is out, then let the block settle
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (sb.boxes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [VALUE_W-1:0] pick_coord();
      case ($urandom_range(4))
         0: return VALUE_W'($urandom);
         1: return VALUE_MAX;
         2: return VALUE_W'($urandom_range(8191));
         default: return VALUE_W'(($urandom_range(1023) << FRAC_BITS) | $urandom_range(4095));
      endcase
   endfunction

   function automatic logic [VALUE_W-1:0] pick_objectness();
      case ($urandom_range(5))
         0: return sb.threshold;
         1: return sb.threshold + 1'b1;
         2: return VALUE_W'($urandom);
         3: return (sb.threshold == '0) ? '0 : VALUE_W'($urandom_range(sb.threshold - 1));
         default: return VALUE_W'($urandom_range(VALUE_MAX, sb.threshold));
      endcase
   endfunction

   task automatic send_random_row();
      logic [VALUE_W-1:0] top_score;
      int                 mode;
      int                 n;
      n = int'(sb.class_count);
      mode = $urandom_range(3);
      top_score = VALUE_W'($urandom);
      repeat (4) send_value(pick_coord());
      send_value(pick_objectness());
      for (int i = 0; i < n; i++) begin
         case (mode)
            0: send_value('0);
            // many equal maxima, the first must win
            1: send_value($urandom_range(1) ? top_score : VALUE_W'($urandom_range(top_score)));
            2: send_value(VALUE_W'($urandom));
            default: send_value(VALUE_W'($urandom_range(15)));
         endcase
      end
   endtask

   initial begin
      int rows;
      logic [VALUE_W-1:0] thr;
      logic [CLASS_W-1:0] classes;

      sb = new;
      sb.restart();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed rows with three classes: extremes, ties, threshold edge, zero scores
      write_reg(REG_CLASS_COUNT, CSR_DATA_W'(3));
      send_value(VALUE_MAX);
      send_value('0);
      send_value(VALUE_MAX);
      send_value('0);
      send_value(VALUE_MAX);
      send_value(VALUE_MAX);
      send_value(VALUE_MAX);
      send_value('0);

      send_value('0);
      send_value(VALUE_MAX);
      send_value(VALUE_MAX);
      send_value(VALUE_W'(3 << FRAC_BITS));
      send_value(THRESHOLD_RESET);
      send_value(VALUE_W'(5));
      send_value(VALUE_W'(9));
      send_value(VALUE_W'(9));

      send_value(VALUE_W'((100 << FRAC_BITS) | 2048));
      send_value(VALUE_W'(4095));
      send_value(VALUE_W'(1 << FRAC_BITS));
      send_value(VALUE_MAX);
      send_value(THRESHOLD_RESET + 1'b1);
      send_value('0);
      send_value('0);
      send_value('0);

      // shrink the class count while a row is half through
      wait_idle();
      write_reg(REG_CLASS_COUNT, CSR_DATA_W'(6));
      send_value(VALUE_W'(40 << FRAC_BITS));
      send_value(VALUE_W'(30 << FRAC_BITS));
      send_value(VALUE_W'(20 << FRAC_BITS));
      send_value(VALUE_W'(10 << FRAC_BITS));
      send_value(VALUE_MAX);
      send_value(VALUE_W'(7));
      send_value(VALUE_W'(11));
      send_value(VALUE_W'(3));
      wait_idle();
      write_reg(REG_CLASS_COUNT, CSR_DATA_W'(2));
      send_value(VALUE_W'(12));

      // rows with no class scores at all
      wait_idle();
      write_reg(REG_CLASS_COUNT, '0);
      repeat (4) send_value(pick_coord());
      send_value(VALUE_MAX);
      repeat (4) send_value(pick_coord());
      send_value('0);
      wait_idle();
      write_reg(REG_SPARE_LOW, '0);
      write_reg(REG_SPARE_HIGH, VALUE_MAX);

      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: begin
               thr = THRESHOLD_RESET;
               classes = CLASS_W'(3);
               idle_pct = 0;
               stall_pct = 0;
               rows = 25;
            end
            1: begin
               thr = '0;
               classes = CLASS_W'(1);
               idle_pct = 57;
               stall_pct = 0;
               rows = 35;
            end
            2: begin
               thr = VALUE_W'($urandom);
               classes = CLASS_W'(4);
               idle_pct = 0;
               stall_pct = 57;
               rows = 25;
            end
            3: begin
               thr = THRESHOLD_RESET;
               classes = CLASS_W'(255);
               idle_pct = 15;
               stall_pct = 15;
               rows = 1;
            end
            4: begin
               thr = VALUE_MAX;
               classes = CLASS_W'(2);
               idle_pct = 0;
               stall_pct = 0;
               rows = 10;
            end
            5: begin
               thr = VALUE_W'($urandom_range(8192));
               classes = CLASS_W'($urandom_range(8, 1));
               idle_pct = 15;
               stall_pct = 15;
               rows = 25;
            end
            default: begin
               thr = VALUE_W'($urandom_range(4096));
               classes = CLASS_COUNT_RESET;
               idle_pct = 0;
               stall_pct = 57;
               rows = 2;
            end
         endcase
         wait_idle();
         write_reg(REG_SCORE_THRESHOLD, CSR_DATA_W'(thr));
         write_reg(REG_CLASS_COUNT, CSR_DATA_W'(classes));
         for (int r = 0; r < rows; r++) begin
            if (phase == 1 && r == rows / 2) begin
               wait_idle();
            end
            send_random_row();
         end
      end

      wait_idle();
      $display("decoded %0d rows from %0d requests, %0d boxes checked", sb.rows_done,
               sb.values_seen, sb.boxes_checked);
      $display("thresholds from zero to full scale, 0 to 255 classes, idle and stall mixes");
      if (sb.mismatches == 0 && sb.boxes_due.size() == 0) begin
         $display("PASS detection_row_decode");
      end else begin
         $display("FAIL detection_row_decode");
      end
      $finish;
   end

endmodule
